@@ design/ridm_pkg.sv @@
// ----------------------------------------------------------------------------
// ridm_pkg
// Shared types and constants for the row to id map lookup block.
// ----------------------------------------------------------------------------
package ridm_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CNT_W    = $clog2(MAX_ROWS + 1);
    localparam int ID_W     = 64;

    typedef enum logic [1:0] {
        MODE_BEGIN = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_FIND  = 2'd2,
        MODE_GET   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NOT_FOUND    = 3'd1,
        ST_OUT_OF_RANGE = 3'd2,
        ST_FULL         = 3'd3,
        ST_NOT_MAPPED   = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]      mode;
        logic [ID_W-1:0] object_id;
        logic [9:0]      row_sel;
    } in_item_t;

    typedef struct packed {
        logic [2:0]      status;
        logic [9:0]      found_row;
        logic [ID_W-1:0] found_id;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_GET_WAIT,
        S_SCAN
    } ctrl_state_t;

    typedef enum logic [2:0] {
        RES_BEGIN,
        RES_LOAD,
        RES_NOT_MAPPED,
        RES_FULL,
        RES_OOR,
        RES_GET,
        RES_FOUND,
        RES_NOT_FOUND
    } res_sel_t;

    typedef struct packed {
        logic     latch;
        logic     rd_get;
        logic     scan_start;
        logic     scan_next;
        logic     emit;
        res_sel_t sel;
    } ctrl_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  mapped;
        logic  full;
        logic  oor;
        logic  empty;
        logic  match;
        logic  last;
        logic  out_free;
    } dp_status_t;

endpackage

@@ design/row_id_map_lookup.sv @@
// ----------------------------------------------------------------------------
// row_id_map_lookup
// Row to 64-bit id map with begin, load, get and find-smallest-row.
// ----------------------------------------------------------------------------
//  channel  | ports                      | item
//  ---------+----------------------------+------------------------------
//  input    | s_valid s_ready s_data     | mode, object_id, row_sel
//  result   | m_valid m_ready m_data     | status, found_row, found_id
//
//  One item at a time. Begin, load and error answers come straight from decode;
//  get waits for one registered read of the id store. Find scans the id store
//  from row 0, one entry a cycle through the single read port, comparing rows up to
//  the row count. Synchronous active-low reset clears the count, mapped flag,
//  output valid and sequencer state; the store needs no clearing. A stalled
//  result is held in the output register; the sequencer waits there.
// ----------------------------------------------------------------------------
module row_id_map_lookup (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ridm_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ridm_pkg::out_item_t m_data
);

    ridm_pkg::ctrl_cmd_t  cmd;
    ridm_pkg::dp_status_t sts;

    ridm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ridm_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ design/ridm_datapath.sv @@
// ----------------------------------------------------------------------------
// ridm_datapath
// Id store, row count, scan pointer, input latch and result register.
// ----------------------------------------------------------------------------
module ridm_datapath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ridm_pkg::in_item_t    s_data,
    input  ridm_pkg::ctrl_cmd_t   cmd,
    output ridm_pkg::dp_status_t  sts,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ridm_pkg::out_item_t   m_data
);

    logic [ridm_pkg::ID_W-1:0]  id_mem [ridm_pkg::MAX_ROWS];
    logic [ridm_pkg::ID_W-1:0]  rd_data_reg;
    logic [ridm_pkg::ROW_W-1:0] rd_addr;
    logic                       rd_en;
    logic                       wr_en;

    ridm_pkg::in_item_t         item_reg;
    logic [ridm_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       mapped_reg, mapped_next;
    logic [ridm_pkg::ROW_W-1:0] ptr_reg, ptr_next;
    logic                       m_valid_reg, m_valid_next;
    ridm_pkg::out_item_t        m_data_reg, m_data_next;
    logic [ridm_pkg::CNT_W-1:0] ptr_plus;

    assign ptr_plus = {1'b0, ptr_reg} + ridm_pkg::CNT_W'(1);

    always_comb begin
        rd_en   = cmd.rd_get | cmd.scan_start | cmd.scan_next;
        rd_addr = item_reg.row_sel;
        if (cmd.scan_start) begin
            rd_addr = '0;
        end else if (cmd.scan_next) begin
            rd_addr = ptr_plus[ridm_pkg::ROW_W-1:0];
        end
        wr_en = cmd.emit && (cmd.sel == ridm_pkg::RES_LOAD);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            id_mem[count_reg[ridm_pkg::ROW_W-1:0]] <= item_reg.object_id;
        end
        if (rd_en) begin
            rd_data_reg <= id_mem[rd_addr];
        end
        if (cmd.latch) begin
            item_reg <= s_data;
        end
    end

    always_comb begin
        sts.mode     = ridm_pkg::mode_t'(item_reg.mode);
        sts.mapped   = mapped_reg;
        sts.full     = (count_reg == ridm_pkg::CNT_W'(ridm_pkg::MAX_ROWS));
        sts.oor      = ({1'b0, item_reg.row_sel} >= count_reg);
        sts.empty    = (count_reg == '0);
        sts.match    = (rd_data_reg == item_reg.object_id);
        sts.last     = (ptr_plus >= count_reg);
        sts.out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        count_next   = count_reg;
        mapped_next  = mapped_reg;
        ptr_next     = ptr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (cmd.scan_start) begin
            ptr_next = '0;
        end else if (cmd.scan_next) begin
            ptr_next = ptr_plus[ridm_pkg::ROW_W-1:0];
        end
        if (cmd.emit) begin
            m_valid_next          = 1'b1;
            m_data_next.status    = ridm_pkg::ST_OK;
            m_data_next.found_row = '0;
            m_data_next.found_id  = '0;
            case (cmd.sel)
                ridm_pkg::RES_BEGIN: begin
                    mapped_next = 1'b1;
                    count_next  = '0;
                end
                ridm_pkg::RES_LOAD: begin
                    m_data_next.found_row = count_reg[ridm_pkg::ROW_W-1:0];
                    count_next            = count_reg + ridm_pkg::CNT_W'(1);
                end
                ridm_pkg::RES_NOT_MAPPED: m_data_next.status = ridm_pkg::ST_NOT_MAPPED;
                ridm_pkg::RES_FULL:       m_data_next.status = ridm_pkg::ST_FULL;
                ridm_pkg::RES_OOR:        m_data_next.status = ridm_pkg::ST_OUT_OF_RANGE;
                ridm_pkg::RES_GET:        m_data_next.found_id = rd_data_reg;
                ridm_pkg::RES_FOUND:      m_data_next.found_row = ptr_reg;
                ridm_pkg::RES_NOT_FOUND:  m_data_next.status = ridm_pkg::ST_NOT_FOUND;
                default:                  m_data_next.status = ridm_pkg::ST_NOT_FOUND;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            mapped_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            mapped_reg  <= mapped_next;
            m_valid_reg <= m_valid_next;
        end
        ptr_reg    <= ptr_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ design/ridm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ridm_ctrl
// Sequencer: decodes the item, runs get reads and find scans.
// ----------------------------------------------------------------------------
module ridm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ridm_pkg::dp_status_t sts,
    output ridm_pkg::ctrl_cmd_t  cmd
);

    ridm_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ridm_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        cmd.latch      = 1'b0;
        cmd.rd_get     = 1'b0;
        cmd.scan_start = 1'b0;
        cmd.scan_next  = 1'b0;
        cmd.emit       = 1'b0;
        cmd.sel        = ridm_pkg::RES_BEGIN;
        case (state_reg)
            ridm_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ridm_pkg::S_DECODE;
                end
            end
            ridm_pkg::S_DECODE: begin
                if (sts.mode == ridm_pkg::MODE_BEGIN) begin
                    cmd.sel = ridm_pkg::RES_BEGIN;
                end else if (!sts.mapped) begin
                    cmd.sel = ridm_pkg::RES_NOT_MAPPED;
                end else if (sts.mode == ridm_pkg::MODE_LOAD) begin
                    cmd.sel = sts.full ? ridm_pkg::RES_FULL : ridm_pkg::RES_LOAD;
                end else if (sts.mode == ridm_pkg::MODE_GET) begin
                    cmd.sel = ridm_pkg::RES_OOR;
                end else begin
                    cmd.sel = ridm_pkg::RES_NOT_FOUND;
                end
                // valid get and nonempty find go to the memory first
                if (sts.mapped && sts.mode == ridm_pkg::MODE_GET && !sts.oor) begin
                    cmd.rd_get = 1'b1;
                    state_next = ridm_pkg::S_GET_WAIT;
                end else if (sts.mapped && sts.mode == ridm_pkg::MODE_FIND && !sts.empty) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ridm_pkg::S_SCAN;
                end else if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ridm_pkg::S_IDLE;
                end
            end
            ridm_pkg::S_GET_WAIT: begin
                cmd.sel = ridm_pkg::RES_GET;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ridm_pkg::S_IDLE;
                end
            end
            ridm_pkg::S_SCAN: begin
                if (sts.match) begin
                    cmd.sel = ridm_pkg::RES_FOUND;
                    if (sts.out_free) begin
                        cmd.emit   = 1'b1;
                        state_next = ridm_pkg::S_IDLE;
                    end
                end else if (sts.last) begin
                    cmd.sel = ridm_pkg::RES_NOT_FOUND;
                    if (sts.out_free) begin
                        cmd.emit   = 1'b1;
                        state_next = ridm_pkg::S_IDLE;
                    end
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            default: begin
                state_next = ridm_pkg::S_IDLE;
            end
        endcase
    end

endmodule
